// File: hw/rtl/mte_pkg.sv
package mte_pkg;

    // Queue depth: events in the scaling pipeline plus those waiting for the serializer
    localparam int FIFO_DEPTH_DEF = 8;

    // Channel message status range and one-data-byte message types
    localparam logic [7:0] STATUS_MIN  = 8'h80;
    localparam logic [7:0] STATUS_MAX  = 8'hEF;
    localparam logic [3:0] HI_PROGRAM  = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;

    // VLQ continuation flag
    localparam logic VLQ_CONT = 1'b1;

    // ms to ticks: gap * 12 / 50 = gap * 6 / 25
    // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for all 32-bit x
    localparam logic [31:0] RECIP_25    = 32'h51EB851F;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [5:0]  DIV_25      = 6'd25;
    localparam logic [6:0]  TICK_DEN    = 7'd50;
    localparam logic [31:0] TICK_MAX    = 32'h0FFFFFFF;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
    } msg_t;

    // Classified item handed from the front to the scaling pipeline
    typedef struct packed {
        logic        valid;
        logic        start;
        logic [31:0] gap;
        msg_t        msg;
    } front_item_t;

    // Queued event: saturated tick delta plus message
    typedef struct packed {
        logic [27:0] ticks;
        msg_t        msg;
    } event_t;

    // 6 * r split into multiples of 25 and the leftover
    typedef struct packed {
        logic [2:0] quo;
        logic [4:0] rem;
    } part_t;

    function automatic part_t scale_part(logic [5:0] r);
        logic [8:0] p;
        part_t      res;
        p = 9'(r) * 9'd6;
        res.quo = 3'd0;
        if (p >= 9'd25)
        begin
            res.quo = 3'd1;
        end
        if (p >= 9'd50)
        begin
            res.quo = 3'd2;
        end
        if (p >= 9'd75)
        begin
            res.quo = 3'd3;
        end
        if (p >= 9'd100)
        begin
            res.quo = 3'd4;
        end
        if (p >= 9'd125)
        begin
            res.quo = 3'd5;
        end
        res.rem = 5'(p - 9'(res.quo) * 9'd25);
        return res;
    endfunction

endpackage

// File: hw/rtl/mte_front.sv
module mte_front #(
    parameter int FIFO_DEPTH = mte_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 new_take,
    input  logic [31:0]          timestamp_ms,
    input  logic [7:0]           status_byte,
    input  logic [7:0]           data1,
    input  logic [7:0]           data2,
    input  logic                 pop,
    output mte_pkg::front_item_t item
);

    localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

    logic                 accept;
    logic                 keep;
    logic                 start;
    logic [31:0]          gap;
    logic                 enter;
    logic [OCC_W-1:0]     occ_reg;
    logic [OCC_W-1:0]     occ_next;
    logic [31:0]          prev_time_reg;
    logic                 have_prev_reg;
    mte_pkg::front_item_t item_reg;
    mte_pkg::front_item_t item_next;

    // Room is reserved for every kept event from acceptance until the serializer takes it
    assign in_ready = (occ_reg < OCC_W'(FIFO_DEPTH));
    assign accept   = in_valid && in_ready;

    // Classification and gap
    assign keep  = (status_byte >= mte_pkg::STATUS_MIN) && (status_byte <= mte_pkg::STATUS_MAX);
    assign start = new_take || !have_prev_reg;
    assign gap   = start ? 32'd0 : (timestamp_ms - prev_time_reg);
    assign enter = accept && keep;

    always_comb
    begin
        item_next.valid      = enter;
        item_next.start      = start;
        item_next.gap        = gap;
        item_next.msg.status = status_byte;
        item_next.msg.data1  = data1;
        item_next.msg.data2  = data2;
    end

    // Occupancy count
    always_comb
    begin
        case ({enter, pop})
            2'b10:   occ_next = occ_reg + OCC_W'(1);
            2'b01:   occ_next = occ_reg - OCC_W'(1);
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            prev_time_reg <= '0;
            have_prev_reg <= 1'b0;
            item_reg      <= '0;
        end
        else
        begin
            occ_reg  <= occ_next;
            item_reg <= item_next;
            if (enter)
            begin
                prev_time_reg <= timestamp_ms;
                have_prev_reg <= 1'b1;
            end
            else if (accept && new_take)
            begin
                // dropped status with new_take: next kept event starts the take
                have_prev_reg <= 1'b0;
            end
        end
    end

    assign item = item_reg;

endmodule

// File: hw/rtl/mte_scale.sv
module mte_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mte_pkg::front_item_t in_item,
    output logic                 wr_en,
    output mte_pkg::event_t      wr_data
);

    // Stage 1: reciprocal product
    logic          s1_valid_reg;
    logic          s1_start_reg;
    mte_pkg::msg_t s1_msg_reg;
    logic [5:0]    s1_gap_lo_reg;
    logic [63:0]   s1_prod_reg;

    // Stage 2: quotient estimate and low remainder
    logic          s2_valid_reg;
    logic          s2_start_reg;
    mte_pkg::msg_t s2_msg_reg;
    logic [28:0]   s2_q_reg;
    logic [5:0]    s2_r_reg;

    // Stage 3: whole ticks before carry, fractional part
    logic          s3_valid_reg;
    logic          s3_start_reg;
    mte_pkg::msg_t s3_msg_reg;
    logic [31:0]   s3_base_reg;
    logic [4:0]    s3_rem_reg;

    logic [5:0]    acc_reg;
    logic [5:0]    acc_next;

    logic [28:0]   q0;
    logic [5:0]    q25_lo;
    logic [5:0]    r0;
    logic          fix;
    logic [28:0]   q;
    logic [5:0]    r;
    mte_pkg::part_t part;
    logic [31:0]   base;
    logic [5:0]    acc_base;
    logic [6:0]    sum;
    logic          carry;
    logic [31:0]   ticks;
    logic [27:0]   ticks_sat;

    // Stage 2 logic: r0 = gap - 25*q0, only the low bits matter (r0 < 50)
    assign q0     = s1_prod_reg[63:mte_pkg::RECIP_SHIFT];
    assign q25_lo = 6'({q0[1:0], 4'b0}) + 6'({q0[2:0], 3'b0}) + q0[5:0];
    assign r0     = s1_gap_lo_reg - q25_lo;

    // Stage 3 logic: correct the estimate, then 6*q + floor(6*r/25)
    assign fix  = (s2_r_reg >= mte_pkg::DIV_25);
    assign q    = s2_q_reg + 29'(fix);
    assign r    = fix ? (s2_r_reg - mte_pkg::DIV_25) : s2_r_reg;
    assign part = mte_pkg::scale_part(r);
    assign base = {1'b0, q, 2'b0} + {2'b0, q, 1'b0} + 32'(part.quo);

    // Output stage: remainder accumulator, carry and saturation
    assign acc_base = s3_start_reg ? 6'd0 : acc_reg;
    assign sum      = 7'(acc_base) + 7'({s3_rem_reg, 1'b0});
    assign carry    = (sum >= mte_pkg::TICK_DEN);
    assign acc_next = carry ? 6'(sum - mte_pkg::TICK_DEN) : sum[5:0];
    assign ticks    = s3_base_reg + 32'(carry);
    assign ticks_sat = (ticks > mte_pkg::TICK_MAX) ? mte_pkg::TICK_MAX[27:0] : ticks[27:0];

    assign wr_en         = s3_valid_reg;
    assign wr_data.ticks = ticks_sat;
    assign wr_data.msg   = s3_msg_reg;

    // Valid bits and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= in_item.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s3_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_start_reg  <= in_item.start;
        s1_msg_reg    <= in_item.msg;
        s1_gap_lo_reg <= in_item.gap[5:0];
        s1_prod_reg   <= 64'(in_item.gap) * 64'(mte_pkg::RECIP_25);

        s2_start_reg  <= s1_start_reg;
        s2_msg_reg    <= s1_msg_reg;
        s2_q_reg      <= q0;
        s2_r_reg      <= r0;

        s3_start_reg  <= s2_start_reg;
        s3_msg_reg    <= s2_msg_reg;
        s3_base_reg   <= base;
        s3_rem_reg    <= part.rem;
    end

endmodule

// File: hw/rtl/mte_fifo.sv
module mte_fifo #(
    parameter int DEPTH = mte_pkg::FIFO_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  mte_pkg::event_t wr_data,
    input  logic            rd_en,
    output mte_pkg::event_t rd_data,
    output logic            not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mte_pkg::event_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    mte_pkg::event_t  head_reg;
    logic             head_valid_reg;
    logic             head_valid_next;

    logic             load_head;
    logic             mem_empty;
    logic             bypass;
    logic             mem_wr;
    logic             mem_rd;

    // Registered head: oldest event, refilled from storage or straight from the write side
    assign load_head = !head_valid_reg || rd_en;
    assign mem_empty = (cnt_reg == '0);
    assign bypass    = load_head && mem_empty && wr_en;
    assign mem_wr    = wr_en && !bypass;
    assign mem_rd    = load_head && !mem_empty;

    assign head_valid_next = load_head ? (!mem_empty || wr_en) : head_valid_reg;

    assign not_empty = head_valid_reg;
    assign rd_data   = head_reg;

    always_comb
    begin
        case ({mem_wr, mem_rd})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    // Pointers and count; overflow is prevented by the front's occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            head_valid_reg <= head_valid_next;
            if (mem_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (mem_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Storage and head load
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (mem_rd)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
        else if (bypass)
        begin
            head_reg <= wr_data;
        end
    end

endmodule

// File: hw/rtl/mte_back.sv
module mte_back (
    input  logic            clk,
    input  logic            rst_n,
    input  mte_pkg::event_t head,
    input  logic            not_empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      track_byte,
    output logic            last
);

    mte_pkg::event_t cur_reg;
    logic [2:0]      ng_reg;
    logic [2:0]      last_pos_reg;
    logic [2:0]      pos_reg;
    logic            busy_reg;
    logic            out_valid_reg;
    logic [7:0]      byte_reg;
    logic            last_reg;

    logic            load_out;
    logic            step;
    logic            cur_last;
    logic [2:0]      head_ng;
    logic            head_two;
    logic [1:0]      grp_idx;
    logic [6:0]      grp;
    logic [2:0]      msg_pos;
    logic [7:0]      sel_byte;

    assign load_out = !out_valid_reg || out_ready;
    assign step     = busy_reg && load_out;
    assign cur_last = (pos_reg == last_pos_reg);
    assign pop      = not_empty && (!busy_reg || (step && cur_last));

    // Byte count of the head event
    always_comb
    begin
        if (head.ticks[27:21] != 7'd0)
        begin
            head_ng = 3'd4;
        end
        else if (head.ticks[20:14] != 7'd0)
        begin
            head_ng = 3'd3;
        end
        else if (head.ticks[13:7] != 7'd0)
        begin
            head_ng = 3'd2;
        end
        else
        begin
            head_ng = 3'd1;
        end
        head_two = (head.msg.status[7:4] != mte_pkg::HI_PROGRAM) &&
                   (head.msg.status[7:4] != mte_pkg::HI_PRESSURE);
    end

    // Byte at the current position: VLQ groups high first, then the message
    assign grp_idx = 2'(ng_reg - pos_reg - 3'd1);
    assign msg_pos = pos_reg - ng_reg;

    always_comb
    begin
        case (grp_idx)
            2'd0:    grp = cur_reg.ticks[6:0];
            2'd1:    grp = cur_reg.ticks[13:7];
            2'd2:    grp = cur_reg.ticks[20:14];
            default: grp = cur_reg.ticks[27:21];
        endcase
        if (pos_reg < ng_reg)
        begin
            sel_byte = {(grp_idx != 2'd0) ? mte_pkg::VLQ_CONT : 1'b0, grp};
        end
        else
        begin
            case (msg_pos)
                3'd0:    sel_byte = cur_reg.msg.status;
                3'd1:    sel_byte = cur_reg.msg.data1;
                default: sel_byte = cur_reg.msg.data2;
            endcase
        end
    end

    // Event sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pos_reg      <= '0;
            ng_reg       <= '0;
            last_pos_reg <= '0;
        end
        else if (pop)
        begin
            busy_reg     <= 1'b1;
            pos_reg      <= '0;
            ng_reg       <= head_ng;
            last_pos_reg <= head_ng + (head_two ? 3'd2 : 3'd1);
        end
        else if (step)
        begin
            if (cur_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            byte_reg <= sel_byte;
            last_reg <= cur_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign track_byte = byte_reg;
    assign last       = last_reg;

endmodule

// File: hw/rtl/midi_track_event_encoder.sv
// Turns timestamped MIDI channel messages into track-chunk event bytes: a delta
// time of 1 to 4 VLQ bytes (ms gap * 12/50 ticks, remainder carried, saturating
// at 0x0FFFFFFF) then status and one or two data bytes; statuses outside
// 0x80..0xEF are dropped and give no bytes. An event is accepted every cycle
// while fewer than FIFO_DEPTH events sit between the input and the byte
// serializer; with the serializer idle the first byte of an event passes the front
// register, three scaling stages, the queue head, the serializer's event register
// and the output byte register. Each event then gives 3 to 7 bytes, depending on
// delta size and message type, one byte per cycle while out_ready is high.
module midi_track_event_encoder #(
    parameter int FIFO_DEPTH = mte_pkg::FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        new_take,
    input  logic [31:0] timestamp_ms,
    input  logic [7:0]  status_byte,
    input  logic [7:0]  data1,
    input  logic [7:0]  data2,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  track_byte,
    output logic        last
);

    mte_pkg::front_item_t item;
    logic                 wr_en;
    mte_pkg::event_t      wr_data;
    mte_pkg::event_t      head;
    logic                 not_empty;
    logic                 pop;

    mte_front #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .new_take    (new_take),
        .timestamp_ms(timestamp_ms),
        .status_byte (status_byte),
        .data1       (data1),
        .data2       (data2),
        .pop         (pop),
        .item        (item)
    );

    mte_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_item(item),
        .wr_en  (wr_en),
        .wr_data(wr_data)
    );

    mte_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .rd_en    (pop),
        .rd_data  (head),
        .not_empty(not_empty)
    );

    mte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .track_byte(track_byte),
        .last      (last)
    );

endmodule
